>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the dispatcher.
// Depends on nothing; the includer supplies clock, reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/dsd_pkg.sv
// Package for the deferred service dispatcher: codes, widths and the command
// and result records passed between the front end, queue and back end.
`timescale 1ns / 1ps
`default_nettype none

package dsd_pkg;

  // Default sizing
  localparam int MAX_SERVICES_DEF    = 8;
  localparam int DISPATCH_BUDGET_DEF = 8;

  // Field widths
  localparam int FUNC_W  = 3;
  localparam int ID_W    = 8;
  localparam int GID_W   = 5;
  localparam int PNOW_W  = 8;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET      = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_ONCE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 3'd4;

  // Classified operation codes
  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_SET      = 3'd2;
  localparam logic [2:0] OP_SET_ONCE = 3'd3;
  localparam logic [2:0] OP_DISPATCH = 3'd4;
  localparam logic [2:0] OP_IGNORE   = 3'd5;

  typedef struct packed {
    logic [2:0]      op;
    logic [ID_W-1:0] svc_id;
    logic            id_ok;
    logic            handler;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              grant_valid;
    logic [GID_W-1:0]  granted_id;
    logic              handled;
    logic              raise_request;
    logic [PNOW_W-1:0] pending_now;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/dsd_front.sv
// Front end of the dispatcher: takes input transactions and classifies them
// into commands for the queue. Depends on dsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsd_front #(
  parameter int MAX_SERVICES = dsd_pkg::MAX_SERVICES_DEF
) (
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [dsd_pkg::FUNC_W-1:0]     in_tuser,  // func
  input  wire logic [dsd_pkg::IN_DATA_W-1:0]  in_tdata,  // service_id, handler_present
  input  wire logic                           q_full,
  output logic                                q_push,
  output dsd_pkg::cmd_t                       q_cmd
);

  logic [dsd_pkg::ID_W-1:0] svc_id;

  assign svc_id    = in_tdata[dsd_pkg::ID_W-1:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Classify function and check the service id range
  always_comb begin
    q_cmd         = '0;
    q_cmd.svc_id  = svc_id;
    q_cmd.handler = in_tdata[dsd_pkg::ID_W];
    q_cmd.id_ok   = {1'b0, svc_id} < (dsd_pkg::ID_W+1)'(MAX_SERVICES);
    case (in_tuser)
      dsd_pkg::FUNC_REGISTER: q_cmd.op = dsd_pkg::OP_REGISTER;
      dsd_pkg::FUNC_CLEAR:    q_cmd.op = dsd_pkg::OP_CLEAR;
      dsd_pkg::FUNC_SET:      q_cmd.op = dsd_pkg::OP_SET;
      dsd_pkg::FUNC_SET_ONCE: q_cmd.op = dsd_pkg::OP_SET_ONCE;
      dsd_pkg::FUNC_DISPATCH: q_cmd.op = dsd_pkg::OP_DISPATCH;
      default:                q_cmd.op = dsd_pkg::OP_IGNORE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dsd_queue.sv
// Short command queue between the dispatcher's front and back ends.
// Depends on dsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire dsd_pkg::cmd_t push_cmd,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output dsd_pkg::cmd_t      head_cmd
);

  dsd_pkg::cmd_t               slot_r [dsd_pkg::QUEUE_DEPTH];
  logic [dsd_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [dsd_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [dsd_pkg::QCNT_W-1:0]  count_r,  count_nxt;

  assign full       = count_r == dsd_pkg::QCNT_W'(dsd_pkg::QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dsd_back.sv
// Dispatcher back end: holds the pending table, executes queued commands one
// step per cycle unless stalled, registers each result. Depends on dsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsd_back #(
  parameter int MAX_SERVICES    = dsd_pkg::MAX_SERVICES_DEF,
  parameter int DISPATCH_BUDGET = dsd_pkg::DISPATCH_BUDGET_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire dsd_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               res_valid,
  input  wire logic          res_ready,
  output dsd_pkg::result_t   res
);

  localparam int IDX_W  = (MAX_SERVICES > 1) ? $clog2(MAX_SERVICES) : 1;
  localparam int STEP_W = (DISPATCH_BUDGET > 1) ? $clog2(DISPATCH_BUDGET) : 1;
  localparam int WIDE_W = (MAX_SERVICES > dsd_pkg::PNOW_W) ? MAX_SERVICES : dsd_pkg::PNOW_W;

  logic [dsd_pkg::COUNT_W-1:0] count_r [MAX_SERVICES];
  logic [MAX_SERVICES-1:0]     pend_r, pend_nxt;
  logic [MAX_SERVICES-1:0]     reg_r,  reg_nxt;
  logic [STEP_W-1:0]           step_r;
  logic                        res_valid_r;
  dsd_pkg::result_t            res_r;

  logic                        lp_any;
  logic [IDX_W-1:0]            lp_idx;
  logic [IDX_W-1:0]            idx;
  logic [dsd_pkg::COUNT_W-1:0] cnt, cnt_nxt;
  logic                        cnt_we;
  logic                        budget_end;
  logic                        step;
  logic [WIDE_W-1:0]           pend_wide;
  dsd_pkg::result_t            out_nxt;

  // Find the lowest pending service
  always_comb begin
    lp_any = 1'b0;
    lp_idx = '0;
    for (int i = MAX_SERVICES - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        lp_any = 1'b1;
        lp_idx = IDX_W'(i);
      end
    end
  end

  assign step       = cmd_valid && (!res_valid_r || res_ready);
  assign idx        = (cmd.op == dsd_pkg::OP_DISPATCH) ? lp_idx : cmd.svc_id[IDX_W-1:0];
  assign cnt        = count_r[idx];
  assign budget_end = step_r == STEP_W'(DISPATCH_BUDGET - 1);

  // Execute one step of the head command
  always_comb begin
    pend_nxt = pend_r;
    reg_nxt  = reg_r;
    cnt_nxt  = cnt;
    cnt_we   = 1'b0;
    out_nxt  = '0;
    out_nxt.last = 1'b1;
    case (cmd.op)
      dsd_pkg::OP_REGISTER: begin
        if (cmd.id_ok && cmd.handler) begin
          cnt_nxt          = '0;
          cnt_we           = 1'b1;
          pend_nxt[idx]    = 1'b0;
          reg_nxt[idx]     = 1'b1;
          out_nxt.accepted = 1'b1;
        end
      end
      dsd_pkg::OP_CLEAR: begin
        if (cmd.id_ok) begin
          cnt_nxt          = '0;
          cnt_we           = 1'b1;
          pend_nxt[idx]    = 1'b0;
          reg_nxt[idx]     = 1'b0;
          out_nxt.accepted = 1'b1;
        end
      end
      dsd_pkg::OP_SET, dsd_pkg::OP_SET_ONCE: begin
        if (cmd.id_ok) begin
          if (cmd.op == dsd_pkg::OP_SET_ONCE) begin
            cnt_nxt = dsd_pkg::COUNT_W'(1);
          end else if (cnt != dsd_pkg::COUNT_MAX) begin
            cnt_nxt = cnt + 1'b1;
          end
          cnt_we                = 1'b1;
          pend_nxt[idx]         = 1'b1;
          out_nxt.accepted      = 1'b1;
          out_nxt.raise_request = 1'b1;
        end
      end
      dsd_pkg::OP_DISPATCH: begin
        out_nxt.accepted = 1'b1;
        if (lp_any) begin
          if (cnt != '0) begin
            cnt_nxt = cnt - 1'b1;
          end
          cnt_we = 1'b1;
          if (cnt_nxt == '0) begin
            pend_nxt[idx] = 1'b0;
          end
          out_nxt.grant_valid   = 1'b1;
          out_nxt.granted_id    = dsd_pkg::GID_W'(idx);
          out_nxt.handled       = reg_r[idx];
          out_nxt.last          = budget_end || (pend_nxt == '0);
          out_nxt.raise_request = budget_end && (pend_nxt != '0);
        end
      end
      default: begin
        out_nxt.last = 1'b1;
      end
    endcase
    pend_wide           = WIDE_W'(pend_nxt);
    out_nxt.pending_now = pend_wide[dsd_pkg::PNOW_W-1:0];
  end

  assign cmd_pop = step && out_nxt.last;

  // Update table state and the grant step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SERVICES; i++) begin
        count_r[i] <= '0;
      end
      pend_r <= '0;
      reg_r  <= '0;
      step_r <= '0;
    end else if (step) begin
      if (cnt_we) begin
        count_r[idx] <= cnt_nxt;
      end
      pend_r <= pend_nxt;
      reg_r  <= reg_nxt;
      step_r <= out_nxt.last ? '0 : STEP_W'(step_r + 1'b1);
    end
  end

  // Hold each result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= out_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

>>> rtl/deferred_service_dispatcher.sv
// Top level of the deferred service dispatcher: front end, command queue and
// back end. Depends on dsd_pkg, dsd_front, dsd_queue and dsd_back.
//
// Usage:
//   Input stream in_*: in_tuser carries func (register, clear, set pending,
//   set pending once, dispatch); in_tdata carries service_id and
//   handler_present. Result stream out_*: one result per event operation,
//   and one result per grant for a dispatch (at least one, at most
//   DISPATCH_BUDGET); out_tlast marks the final result of an input item.
//   An accepted input transaction is written into the command queue; the
//   back end executes it from the queue head and registers its result.
//   Throughput: the back end makes one result per cycle while out_tready
//   does not stall it; a dispatch makes one result per grant, and the grant
//   loop over the pending table in the back end sets the rate.
//   A two-entry command queue lets the front end keep taking transactions
//   while the back end works or waits.
//   Reset clears all pending counts, the pending and registered masks, the
//   queue and the result valid flag. When out_tready is low the current result
//   holds, the back end stops, and in_tready drops once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module deferred_service_dispatcher #(
  parameter int MAX_SERVICES    = dsd_pkg::MAX_SERVICES_DEF,
  parameter int DISPATCH_BUDGET = dsd_pkg::DISPATCH_BUDGET_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [dsd_pkg::FUNC_W-1:0]      in_tuser,   // [2:0] func
  input  wire logic [dsd_pkg::IN_DATA_W-1:0]   in_tdata,   // [7:0] service_id, [8] handler_present
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic                                 out_tuser,  // [0] grant_valid
  output logic [dsd_pkg::OUT_DATA_W-1:0]       out_tdata,  // [0] accepted, [5:1] granted_id,
                                                           // [6] handled, [7] raise_request,
                                                           // [15:8] pending_now
  output logic                                 out_tlast
);

  logic             q_full;
  logic             q_push;
  dsd_pkg::cmd_t    q_cmd;
  logic             q_pop;
  logic             head_valid;
  dsd_pkg::cmd_t    head_cmd;
  dsd_pkg::result_t res;

  dsd_front #(
    .MAX_SERVICES (MAX_SERVICES)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  dsd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  dsd_back #(
    .MAX_SERVICES    (MAX_SERVICES),
    .DISPATCH_BUDGET (DISPATCH_BUDGET)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result transaction
  assign out_tuser = res.grant_valid;
  assign out_tlast = res.last;
  assign out_tdata = {res.pending_now, res.raise_request, res.handled,
                      res.granted_id, res.accepted};

endmodule

`default_nettype wire

>>> rtl/dsd_checker.sv
// Port-level checker for the deferred service dispatcher, bound to the top
// level. Depends on dsd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dsd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [dsd_pkg::FUNC_W-1:0]    in_tuser,
  input wire logic [dsd_pkg::IN_DATA_W-1:0] in_tdata,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic                          out_tuser,
  input wire logic [dsd_pkg::OUT_DATA_W-1:0] out_tdata,
  input wire logic                          out_tlast
);

  logic out_stall;
  logic in_stall;
  logic nogrant_ok;

  assign out_stall  = out_tvalid && !out_tready;
  assign in_stall   = in_tvalid && !in_tready;
  assign nogrant_ok = out_tlast && (out_tdata[6:1] == '0);

  // Hold a stalled result transaction
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // Hold a stalled input transaction
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_stall, in_tvalid && $stable({in_tuser, in_tdata}))

  // Results without a grant carry no id and end their item
  `ASSERT_SAME(a_nogrant_last, clk, rst_n, out_tvalid && !out_tuser, nogrant_ok)

  // Request only on the final result of an item
  `ASSERT_SAME(a_req_last, clk, rst_n, out_tvalid && out_tdata[7], out_tlast)

  // Grants are always accepted operations
  `ASSERT_SAME(a_grant_acc, clk, rst_n, out_tvalid && out_tuser, out_tdata[0])

endmodule

bind deferred_service_dispatcher dsd_checker u_dsd_checker (.*);

`default_nettype wire

>>> sim/tb_deferred_service_dispatcher.sv
// Self-checking bench for deferred_service_dispatcher: streams service
// commands, predicts grants and pending masks, checks every result transaction.
// Depends on dsd_pkg and the dispatcher RTL.
`timescale 1ns / 1ps

module tb_deferred_service_dispatcher;
  import dsd_pkg::*;

  localparam int NUM_SVC = MAX_SERVICES_DEF;
  localparam int BUDGET  = DISPATCH_BUDGET_DEF;

  // Function codes the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_RSVD_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_7 = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   svc_id;
    logic              handler;
    bit                drain_first;  // hold until every predicted result is back
    bit                quiet;        // no receiver stalls while this one is in flight
    int                gap;          // idle cycles before presenting
  } svc_cmd_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [FUNC_W-1:0]     in_tuser   = '0;  // [2:0] func
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [7:0] service_id, [8] handler_present
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  out_tuser;        // [0] grant_valid
  logic [OUT_DATA_W-1:0] out_tdata;        // [0] accepted, [5:1] granted_id, [6] handled,
                                           // [7] raise_request, [15:8] pending_now
  logic                  out_tlast;

  deferred_service_dispatcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Shadow of the pending table
  logic [COUNT_W-1:0] svc_count [NUM_SVC];
  logic [NUM_SVC-1:0] pend_mask;
  logic [NUM_SVC-1:0] reg_mask;

  svc_cmd_t svc_cmd_q[$];
  result_t  svc_results_q[$];
  svc_cmd_t cur_cmd;
  int       fail_count;
  int       recv_wait;
  bit       rx_quiet;
  bit       fill_quiet;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reset
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int draw_idle();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  task automatic push_result(input logic acc, input logic gv, input int gid,
                             input logic hd, input logic rr, input logic last);
    result_t r;
    r.accepted      = acc;
    r.grant_valid   = gv;
    r.granted_id    = gid[GID_W-1:0];
    r.handled       = hd;
    r.raise_request = rr;
    r.pending_now   = pend_mask;
    r.last          = last;
    svc_results_q.push_back(r);
  endtask

  // Update the shadow table for one accepted command and queue its results
  task automatic apply_service_op(input svc_cmd_t cmd);
    logic id_ok;
    int   lowest;
    int   n;
    id_ok = (cmd.svc_id < NUM_SVC);
    case (cmd.func)
      FUNC_REGISTER: begin
        if (id_ok && cmd.handler) begin
          svc_count[cmd.svc_id] = '0;
          pend_mask[cmd.svc_id] = 1'b0;
          reg_mask[cmd.svc_id]  = 1'b1;
          push_result(1'b1, 1'b0, 0, 1'b0, 1'b0, 1'b1);
        end else begin
          push_result(1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b1);
        end
      end
      FUNC_CLEAR: begin
        if (id_ok) begin
          svc_count[cmd.svc_id] = '0;
          pend_mask[cmd.svc_id] = 1'b0;
          reg_mask[cmd.svc_id]  = 1'b0;
        end
        push_result(id_ok, 1'b0, 0, 1'b0, 1'b0, 1'b1);
      end
      FUNC_SET, FUNC_SET_ONCE: begin
        if (id_ok) begin
          if (cmd.func == FUNC_SET_ONCE)
            svc_count[cmd.svc_id] = COUNT_W'(1);
          else if (svc_count[cmd.svc_id] != COUNT_MAX)
            svc_count[cmd.svc_id] = svc_count[cmd.svc_id] + 1'b1;
          pend_mask[cmd.svc_id] = 1'b1;
        end
        push_result(id_ok, 1'b0, 0, 1'b0, id_ok, 1'b1);
      end
      FUNC_DISPATCH: begin
        n = 0;
        // Serve the lowest pending service until the budget or the mask runs out
        while (n < BUDGET && pend_mask != '0) begin
          lowest = 0;
          for (int i = NUM_SVC - 1; i >= 0; i--)
            if (pend_mask[i]) lowest = i;
          if (svc_count[lowest] != '0) svc_count[lowest] = svc_count[lowest] - 1'b1;
          if (svc_count[lowest] == '0) pend_mask[lowest] = 1'b0;
          push_result(1'b1, 1'b1, lowest, reg_mask[lowest],
                      (n + 1 >= BUDGET) && (pend_mask != '0),
                      (n + 1 >= BUDGET) || (pend_mask == '0));
          n++;
        end
        if (n == 0) push_result(1'b1, 1'b0, 0, 1'b0, 1'b0, 1'b1);
      end
      default: push_result(1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b1);
    endcase
  endtask

  task automatic post_cmd(input logic [FUNC_W-1:0] func, input int id,
                          input logic hp, input bit drain);
    svc_cmd_t c;
    c.func        = func;
    c.svc_id      = id[ID_W-1:0];
    c.handler     = hp;
    c.drain_first = drain;
    c.quiet       = fill_quiet;
    c.gap         = fill_quiet ? 0 : draw_idle();
    svc_cmd_q.push_back(c);
  endtask

  function automatic int pick_id();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, NUM_SVC - 1);
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return FUNC_REGISTER;
    if (r < 20) return FUNC_CLEAR;
    if (r < 50) return FUNC_SET;
    if (r < 62) return FUNC_SET_ONCE;
    if (r < 94) return FUNC_DISPATCH;
    return FUNC_W'($urandom_range(FUNC_RSVD_5, FUNC_RSVD_7));
  endfunction

  // Driver: present queued commands, predict on every accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      foreach (svc_count[i]) svc_count[i] = '0;
      pend_mask = '0;
      reg_mask  = '0;
    end else begin
      if (in_tvalid && in_tready) apply_service_op(cur_cmd);
      if (!in_tvalid || in_tready) begin
        if (svc_cmd_q.size() != 0 && svc_cmd_q[0].gap > 0) begin
          svc_cmd_q[0].gap = svc_cmd_q[0].gap - 1;
          in_tvalid <= 1'b0;
        end else if (svc_cmd_q.size() != 0 &&
                     !(svc_cmd_q[0].drain_first && svc_results_q.size() != 0)) begin
          cur_cmd  = svc_cmd_q.pop_front();
          rx_quiet = cur_cmd.quiet;
          in_tvalid <= 1'b1;
          in_tuser  <= cur_cmd.func;
          in_tdata  <= {{(IN_DATA_W - ID_W - 1){1'b0}}, cur_cmd.handler, cur_cmd.svc_id};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: stall at random, check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (svc_results_q.size() == 0) begin
          $error("result transaction with no prediction pending");
          fail_count++;
        end else begin
          compare_field("accepted", 16'(svc_results_q[0].accepted), 16'(out_tdata[0]));
          compare_field("grant_valid", 16'(svc_results_q[0].grant_valid), 16'(out_tuser));
          compare_field("granted_id", 16'(svc_results_q[0].granted_id), 16'(out_tdata[5:1]));
          compare_field("handled", 16'(svc_results_q[0].handled), 16'(out_tdata[6]));
          compare_field("raise_request", 16'(svc_results_q[0].raise_request),
                        16'(out_tdata[7]));
          compare_field("pending_now", 16'(svc_results_q[0].pending_now),
                        16'(out_tdata[15:8]));
          compare_field("last", 16'(svc_results_q[0].last), 16'(out_tlast));
          void'(svc_results_q.pop_front());
        end
        recv_wait = rx_quiet ? 0 : draw_idle();
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    int made;
    int id;
    int k;
    fail_count = 0;
    fill_quiet = 1'b0;

    // Directed: empty dispatch, rejects, early stop, budget spent, reserved codes
    post_cmd(FUNC_DISPATCH, 0, 1'b0, 1'b0);
    post_cmd(FUNC_REGISTER, 0, 1'b1, 1'b0);
    post_cmd(FUNC_REGISTER, 1, 1'b0, 1'b0);
    post_cmd(FUNC_REGISTER, 8, 1'b1, 1'b0);
    post_cmd(FUNC_REGISTER, 255, 1'b1, 1'b0);
    post_cmd(FUNC_SET, 0, 1'b0, 1'b0);
    post_cmd(FUNC_SET, 0, 1'b1, 1'b0);
    post_cmd(FUNC_SET_ONCE, 3, 1'b0, 1'b0);
    post_cmd(FUNC_SET, 7, 1'b0, 1'b0);
    post_cmd(FUNC_SET, 255, 1'b1, 1'b0);
    post_cmd(FUNC_SET_ONCE, 8, 1'b0, 1'b0);
    post_cmd(FUNC_CLEAR, 200, 1'b1, 1'b0);
    post_cmd(FUNC_RSVD_5, 0, 1'b0, 1'b0);
    post_cmd(FUNC_RSVD_6, 3, 1'b1, 1'b0);
    post_cmd(FUNC_RSVD_7, 255, 1'b1, 1'b0);
    post_cmd(FUNC_DISPATCH, 255, 1'b1, 1'b0);
    post_cmd(FUNC_SET, 5, 1'b0, 1'b0);
    post_cmd(FUNC_SET, 5, 1'b0, 1'b0);
    post_cmd(FUNC_SET_ONCE, 5, 1'b0, 1'b0);
    repeat (4) post_cmd(FUNC_SET, 6, 1'b0, 1'b0);
    post_cmd(FUNC_SET, 4, 1'b0, 1'b0);
    post_cmd(FUNC_SET, 4, 1'b0, 1'b0);
    post_cmd(FUNC_SET, 4, 1'b0, 1'b0);
    post_cmd(FUNC_DISPATCH, 0, 1'b0, 1'b0);
    post_cmd(FUNC_CLEAR, 0, 1'b0, 1'b0);
    post_cmd(FUNC_DISPATCH, 0, 1'b0, 1'b1);

    // Random: chunks with or without idling, each opening after a full drain
    for (int chunk = 0; chunk < 8; chunk++) begin
      fill_quiet = ($urandom_range(0, 3) == 0);
      made = 0;
      post_cmd(pick_func(), pick_id(), 1'($urandom_range(0, 1)), 1'b1);
      while (made < 50) begin
        if ($urandom_range(0, 9) < 4) begin
          // Well-formed burst: register, post a run of events, dispatch
          id = $urandom_range(0, NUM_SVC - 1);
          k  = $urandom_range(1, 12);
          post_cmd(FUNC_REGISTER, id, 1'b1, 1'b0);
          repeat (k) begin
            if ($urandom_range(0, 1) == 0) id = $urandom_range(0, NUM_SVC - 1);
            post_cmd(($urandom_range(0, 4) == 0) ? FUNC_SET_ONCE : FUNC_SET, id,
                     1'($urandom_range(0, 1)), 1'b0);
          end
          repeat ($urandom_range(1, 2)) post_cmd(FUNC_DISPATCH, pick_id(),
                                                 1'($urandom_range(0, 1)), 1'b0);
          made += k + 3;
        end else begin
          post_cmd(pick_func(), pick_id(), ($urandom_range(0, 3) != 0), 1'b0);
          made++;
        end
      end
      while (svc_cmd_q.size() != 0) @(posedge clk);
    end

    // Wait for the tail, then let the pipeline settle
    while (svc_cmd_q.size() != 0 || in_tvalid || svc_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && svc_results_q.size() == 0)
      $display("** deferred_service_dispatcher: PASSED **");
    else
      $display("** deferred_service_dispatcher: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("** deferred_service_dispatcher: FAILED **");
    $finish;
  end

endmodule
